// File: rtl/mlfqs_fixed_point_update_unit_assert.svh
// Assertion macros shared by the fixed-point update unit checkers.
`ifndef MLFQS_FIXED_POINT_UPDATE_UNIT_ASSERT_SVH
`define MLFQS_FIXED_POINT_UPDATE_UNIT_ASSERT_SVH

`define MFPU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mfpu assertion failed");

`define MFPU_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
  `MFPU_ASSERT(lbl, clk, rst_n, (cond) |=> $stable(sig))

`endif

// File: rtl/mfpu_pkg.sv
// Shared types and constants of the scheduler fixed-point update unit.
package mfpu_pkg;

  typedef enum logic [1:0] {
    CMD_RECALC   = 2'd0,
    CMD_PRIORITY = 2'd1,
    CMD_LOAD     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DISPATCH = 9'b000000010,
    ST_MUL_LO   = 9'b000000100,
    ST_MUL_HI   = 9'b000001000,
    ST_DIV_LOAD = 9'b000010000,
    ST_DIV      = 9'b000100000,
    ST_FIN      = 9'b001000000,
    ST_PRIO     = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_e;

  localparam int unsigned DIV_STEPS      = 32;
  localparam int unsigned CNT_W          = $clog2(DIV_STEPS);
  localparam int unsigned LOAD_DECAY_NUM = 59;
  localparam int unsigned LOAD_DECAY_DEN = 60;
  localparam int unsigned LOAD_SCALE     = 100;

  typedef struct packed {
    logic capture;
    logic mul_lo;
    logic mul_hi;
    logic div_load;
    logic div_step;
    logic finish;
    logic prio;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic exempt;
  } status_t;

endpackage

// File: rtl/mlfqs_fixed_point_update_unit.sv
// Top level of the scheduler fixed-point update unit: controller and datapath.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   command, recent_cpu_in, nice_in,
//                                               ready_count, exempt, priority_in
//   out      output     out_valid_o/out_ready_i recent_cpu_out, priority_out,
//                                               load_avg_x100
//
// A thread recalculation runs through the two-pass 32x16 multiplier and the
// 32-step restoring divider; a load update or a priority only skips them, and
// exempt threads and the unused command go straight to the result. One item
// is in flight; the next beat is taken the cycle after the result is
// registered, even while that result waits on out_ready_i.
// Reset clears the load average and the control state.
module mlfqs_fixed_point_update_unit #(
  parameter int unsigned FRACTION_BITS = 14,
  parameter int unsigned PRIORITY_TOP  = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] recent_cpu_in_i,
  input  logic signed [5:0]  nice_in_i,
  input  logic [7:0]         ready_count_i,
  input  logic               exempt_i,
  input  logic [5:0]         priority_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] recent_cpu_out_o,
  output logic [5:0]         priority_out_o,
  output logic [30:0]        load_avg_x100_o
);
  import mfpu_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  mfpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  mfpu_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .PRIORITY_TOP  (PRIORITY_TOP)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .command_i        (command_i),
    .recent_cpu_in_i  (recent_cpu_in_i),
    .nice_in_i        (nice_in_i),
    .ready_count_i    (ready_count_i),
    .exempt_i         (exempt_i),
    .priority_in_i    (priority_in_i),
    .recent_cpu_out_o (recent_cpu_out_o),
    .priority_out_o   (priority_out_o),
    .load_avg_x100_o  (load_avg_x100_o)
  );

endmodule

// File: rtl/mfpu_ctrl.sv
// Sequencing state machine of the fixed-point update unit.
module mfpu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mfpu_pkg::status_t status_i,
  output mfpu_pkg::ctrl_t   ctrl_o
);
  import mfpu_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ctrl_o     = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.cmd)
          CMD_RECALC:   state_d = status_i.exempt ? ST_DONE : ST_MUL_LO;
          CMD_PRIORITY: state_d = status_i.exempt ? ST_DONE : ST_PRIO;
          CMD_LOAD:     state_d = ST_FIN;
          default:      state_d = ST_DONE;
        endcase
      end
      ST_MUL_LO: begin
        ctrl_o.mul_lo = 1'b1;
        state_d       = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        ctrl_o.mul_hi = 1'b1;
        state_d       = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        ctrl_o.div_load = 1'b1;
        cnt_d           = '0;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        ctrl_o.finish = 1'b1;
        state_d       = (status_i.cmd == CMD_LOAD) ? ST_DONE : ST_PRIO;
      end
      ST_PRIO: begin
        ctrl_o.prio = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/mfpu_datapath.sv
// Operand registers, shared multiplier, restoring divider and result registers.
module mfpu_datapath #(
  parameter int unsigned FRACTION_BITS = 14,
  parameter int unsigned PRIORITY_TOP  = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfpu_pkg::ctrl_t     ctrl_i,
  output mfpu_pkg::status_t   status_o,
  input  logic [1:0]          command_i,
  input  logic signed [31:0]  recent_cpu_in_i,
  input  logic signed [5:0]   nice_in_i,
  input  logic [7:0]          ready_count_i,
  input  logic                exempt_i,
  input  logic [5:0]          priority_in_i,
  output logic signed [31:0]  recent_cpu_out_o,
  output logic [5:0]          priority_out_o,
  output logic [30:0]         load_avg_x100_o
);
  import mfpu_pkg::*;

  localparam int unsigned PT_W   = $clog2(PRIORITY_TOP + 1);
  localparam int unsigned XW     = ((PT_W + FRACTION_BITS + 2) > 34) ?
                                   (PT_W + FRACTION_BITS + 2) : 34;
  localparam int unsigned PW     = XW - FRACTION_BITS;
  localparam int unsigned COEF_I = (LOAD_DECAY_NUM << FRACTION_BITS) / LOAD_DECAY_DEN;
  localparam logic [FRACTION_BITS:0] COEF = (FRACTION_BITS + 1)'(COEF_I);
  localparam logic [63:0] FRAC_MASK = ~((64'd1 << FRACTION_BITS) - 64'd1);
  localparam logic [32:0] FP_ONE    = 33'd1 << FRACTION_BITS;
  localparam logic [38:0] HALF      = 39'd1 << (FRACTION_BITS - 1);
  localparam logic [XW-1:0] PT_FIX  = XW'(PRIORITY_TOP) << FRACTION_BITS;
  localparam int unsigned RSH       = FRACTION_BITS + 14;
  localparam int unsigned RPW       = 2 * FRACTION_BITS + 17;
  localparam logic [63:0] RECIP_I   = ((64'd1 << RSH) + 64'(LOAD_DECAY_DEN) - 64'd1) /
                                      64'(LOAD_DECAY_DEN);
  localparam logic [FRACTION_BITS+8:0] RECIP = (FRACTION_BITS + 9)'(RECIP_I);

  cmd_e               cmd_q;
  logic               exempt_q;
  logic signed [31:0] r_q;
  logic signed [5:0]  nice_q;
  logic [7:0]         ready_q;
  logic [5:0]         pin_q;
  logic               neg_q;
  logic [31:0]        mag_q;
  logic [30:0]        load_q;
  logic [63:0]        acc_q;
  logic [32:0]        rem_q;
  logic [31:0]        dlo_q;
  logic [32:0]        den_q;
  logic [5:0]         prio_q;
  logic signed [31:0] rout_q;
  logic [5:0]         pout_q;
  logic [30:0]        lout_q;

  logic [31:0] twice;
  logic [15:0] half;
  logic [47:0] prod;
  logic [63:0] dvd;
  logic [33:0] sh;
  logic [33:0] df;
  logic        ge;

  assign twice = {load_q, 1'b0};
  assign half  = ctrl_i.mul_hi ? mag_q[31:16] : mag_q[15:0];
  assign prod  = 48'(twice) * 48'(half);
  assign dvd   = acc_q & FRAC_MASK;
  assign sh    = {rem_q, dlo_q[31]};
  assign df    = sh - {1'b0, den_q};
  assign ge    = (sh >= {1'b0, den_q});

  logic signed [33:0] qs;
  logic signed [33:0] nfix;
  logic signed [33:0] rsum;
  logic signed [31:0] rsat;

  assign qs   = neg_q ? -$signed({2'b00, dlo_q}) : $signed({2'b00, dlo_q});
  assign nfix = $signed({{28{nice_q[5]}}, nice_q}) <<< FRACTION_BITS;
  assign rsum = qs + nfix;

  always_comb begin
    if (rsum[33:31] == 3'b000 || rsum[33:31] == 3'b111) begin
      rsat = rsum[31:0];
    end else if (rsum[33]) begin
      rsat = 32'sh8000_0000;
    end else begin
      rsat = 32'sh7fff_ffff;
    end
  end

  logic [FRACTION_BITS+31:0] lprod;
  logic [RPW-1:0]            rprod;
  logic [31:0]               rdiv;
  logic [32:0]               lsum;
  logic [30:0]               lnew;

  assign lprod = (FRACTION_BITS + 32)'(COEF) * (FRACTION_BITS + 32)'(load_q);
  assign rprod = RPW'({ready_q, {FRACTION_BITS{1'b0}}}) * RPW'(RECIP);
  assign rdiv  = 32'(rprod[RPW-1:RSH]);
  assign lsum  = {1'b0, lprod[FRACTION_BITS+31:FRACTION_BITS]} + {1'b0, rdiv};
  assign lnew  = (lsum[32:31] != 2'b00) ? 31'h7fff_ffff : lsum[30:0];

  logic signed [32:0]   r_adj;
  logic signed [32:0]   r_q4;
  logic signed [XW-1:0] nfix2;
  logic signed [XW-1:0] px;
  logic [PW-1:0]        pint;
  logic [PW-1:0]        pval;

  assign r_adj = $signed({r_q[31], r_q}) + (r_q[31] ? 33'sd3 : 33'sd0);
  assign r_q4  = r_adj >>> 2;
  assign nfix2 = $signed({{(XW - 6){nice_q[5]}}, nice_q}) <<< (FRACTION_BITS + 1);
  assign px    = $signed(PT_FIX) - $signed({{(XW - 33){r_q4[32]}}, r_q4}) - nfix2;
  assign pint  = px[XW-1:FRACTION_BITS];

  always_comb begin
    if (px[XW-1]) begin
      pval = '0;
    end else if (pint > PW'(PRIORITY_TOP)) begin
      pval = PW'(PRIORITY_TOP);
    end else begin
      pval = pint;
    end
  end

  logic [37:0] x100;
  logic [38:0] xr;
  logic [38:0] xs;

  assign x100 = 38'(load_q) * 38'(LOAD_SCALE);
  assign xr   = {1'b0, x100} + HALF;
  assign xs   = xr >> FRACTION_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else if (ctrl_i.finish && cmd_q == CMD_LOAD) begin
      load_q <= lnew;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q    <= cmd_e'(command_i);
      exempt_q <= exempt_i;
      r_q      <= recent_cpu_in_i;
      nice_q   <= nice_in_i;
      ready_q  <= ready_count_i;
      pin_q    <= priority_in_i;
      neg_q    <= recent_cpu_in_i[31];
      mag_q    <= recent_cpu_in_i[31] ? 32'(-recent_cpu_in_i) : recent_cpu_in_i;
    end
    if (ctrl_i.mul_lo) begin
      acc_q <= 64'(prod);
    end
    if (ctrl_i.mul_hi) begin
      acc_q <= acc_q + {prod, 16'b0};
    end
    if (ctrl_i.div_load) begin
      rem_q <= {1'b0, dvd[63:32]};
      dlo_q <= dvd[31:0];
      den_q <= {1'b0, twice} + FP_ONE;
    end
    if (ctrl_i.div_step) begin
      rem_q <= ge ? df[32:0] : sh[32:0];
      dlo_q <= {dlo_q[30:0], ge};
    end
    if (ctrl_i.finish && cmd_q == CMD_RECALC) begin
      r_q <= rsat;
    end
    if (ctrl_i.prio) begin
      prio_q <= pval[5:0];
    end
    if (ctrl_i.out_load) begin
      lout_q <= xs[30:0];
      if (cmd_q == CMD_RECALC || cmd_q == CMD_PRIORITY) begin
        rout_q <= r_q;
        pout_q <= exempt_q ? pin_q : prio_q;
      end else begin
        rout_q <= '0;
        pout_q <= '0;
      end
    end
  end

  assign status_o.cmd    = cmd_q;
  assign status_o.exempt = exempt_q;

  assign recent_cpu_out_o = rout_q;
  assign priority_out_o   = pout_q;
  assign load_avg_x100_o  = lout_q;

endmodule

// File: rtl/mfpu_checker.sv
// Port-level checker of the fixed-point update unit and its bind.
`include "mlfqs_fixed_point_update_unit_assert.svh"

module mfpu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] recent_cpu_out_o,
  input logic [5:0]         priority_out_o,
  input logic [30:0]        load_avg_x100_o
);

  logic [69:0] out_beat;

  assign out_beat = {out_valid_o, recent_cpu_out_o, priority_out_o, load_avg_x100_o};

  `MFPU_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_beat)
  `MFPU_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `MFPU_ASSERT(a_no_instant_result, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
  `MFPU_ASSERT(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> !$past(in_ready_o))

endmodule

bind mlfqs_fixed_point_update_unit mfpu_checker u_mfpu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .recent_cpu_out_o (recent_cpu_out_o),
  .priority_out_o   (priority_out_o),
  .load_avg_x100_o  (load_avg_x100_o)
);
